// File: rtl/core/slt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table: operation kinds,
// status codes and field widths.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // operation carried by one input item
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT    = 2'd0,
    KIND_DEL_VALUE = 2'd1,
    KIND_DEL_MIN   = 2'd2,
    KIND_DEL_MAX   = 2'd3
  } kind_t;

  // status returned with each result item
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/slt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/sorted_list_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Keeps up to DEPTH signed 32-bit values in ascending order in one RAM and
// runs insert, delete-by-value, delete-smallest and delete-largest items.
// ----------------------------------------------------------------------------
// One item is handled at a time. The entries live in a RAM with one write
// and one registered read port; each operation streams through the RAM one
// entry per cycle, reading an entry and writing the shifted entry back in
// the same pass. An insert walks down from the top of the list; a delete
// walks up from the bottom to the top, except delete-largest, which reads
// only the top entry. A full insert or a delete on an empty list reads
// nothing and goes straight to the result. The unit is back in idle when
// the result appears and can take the next item while that result is
// shown. A new item is taken while the previous result still waits in
// the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_list_table_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // operation items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [slt_pkg::KIND_W-1:0]    in_kind,
  input  wire logic signed [slt_pkg::DATA_W-1:0] in_operand_value,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [slt_pkg::STATUS_W-1:0]       out_status,
  output logic signed [slt_pkg::DATA_W-1:0]  out_removed_value,
  output logic [slt_pkg::COUNT_W-1:0]        out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RESP
  } state_t;

  state_t                         state_r, state_nxt;
  slt_pkg::kind_t                 kind_r, kind_nxt;
  logic signed [slt_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  last_r, last_nxt;
  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic                           iss_r, iss_nxt;
  logic                           dv_r, dv_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic                           found_r, found_nxt;
  logic [slt_pkg::DATA_W-1:0]     removed_r, removed_nxt;
  slt_pkg::status_t               status_r, status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  slt_pkg::status_t               out_status_r, out_status_nxt;
  logic [slt_pkg::DATA_W-1:0]     out_removed_r, out_removed_nxt;
  logic [slt_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [slt_pkg::DATA_W-1:0]     ram_wdata;
  logic [slt_pkg::DATA_W-1:0]     ram_rdata;

  logic                           in_acc;
  logic [AW-1:0]                  top_idx;
  logic                           shift;
  logic                           match;

  slt_ram #(
    .WIDTH (slt_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign top_idx  = AW'(count_r - CW'(1));

  // insert: entry moves up while it belongs above the new value;
  // at the bottom the new value goes in front of an equal smallest entry
  assign shift = (idx_r == '0) ? (val_r <= $signed(ram_rdata))
                               : ($signed(ram_rdata) > val_r);
  assign match = (kind_r == slt_pkg::KIND_DEL_VALUE) ?
                 (ram_rdata == val_r) : 1'b1;

  // operation sequencer
  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    val_nxt         = val_r;
    count_nxt       = count_r;
    last_nxt        = last_r;
    ptr_nxt         = ptr_r;
    iss_nxt         = iss_r;
    dv_nxt          = 1'b0;
    idx_nxt         = idx_r;
    found_nxt       = found_r;
    removed_nxt     = removed_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt    = slt_pkg::kind_t'(in_kind);
          val_nxt     = in_operand_value;
          found_nxt   = 1'b0;
          removed_nxt = '0;
          status_nxt  = slt_pkg::ST_OK;
          iss_nxt     = 1'b1;
          last_nxt    = top_idx;
          if (slt_pkg::kind_t'(in_kind) == slt_pkg::KIND_INSERT) begin
            ptr_nxt = top_idx;
            if (count_r == CW'(DEPTH)) begin
              status_nxt = slt_pkg::ST_FULL;
              state_nxt  = S_RESP;
            end else if (count_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            ptr_nxt = (slt_pkg::kind_t'(in_kind) == slt_pkg::KIND_DEL_MAX) ?
                      top_idx : '0;
            if (count_r == '0) begin
              status_nxt = slt_pkg::ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // issue the next read
        if (iss_r) begin
          dv_nxt  = 1'b1;
          idx_nxt = ptr_r;
          if (kind_r == slt_pkg::KIND_INSERT) begin
            if (ptr_r == '0) begin
              iss_nxt = 1'b0;
            end else begin
              ptr_nxt = ptr_r - AW'(1);
            end
          end else begin
            if (ptr_r == last_r) begin
              iss_nxt = 1'b0;
            end else begin
              ptr_nxt = ptr_r + AW'(1);
            end
          end
        end
        // handle the entry read last cycle
        if (dv_r) begin
          if (kind_r == slt_pkg::KIND_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = idx_r + AW'(1);
            ram_wdata = shift ? ram_rdata : val_r;
            if (!shift) begin
              state_nxt = S_RESP;
            end else if (idx_r == '0) begin
              state_nxt = S_FIN;
            end
          end else begin
            if (found_r) begin
              ram_we    = 1'b1;
              ram_waddr = idx_r - AW'(1);
              ram_wdata = ram_rdata;
            end else if (match) begin
              found_nxt   = 1'b1;
              removed_nxt = ram_rdata;
            end
            if (idx_r == last_r) begin
              state_nxt  = S_RESP;
              status_nxt = (found_r || match) ? slt_pkg::ST_OK
                                              : slt_pkg::ST_NOTFOUND;
            end
          end
        end
        if (state_nxt != S_SCAN) begin
          iss_nxt = 1'b0;
          dv_nxt  = 1'b0;
        end
      end

      S_FIN: begin
        // new value lands at the bottom of the list
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          if (status_r == slt_pkg::ST_OK) begin
            if (kind_r == slt_pkg::KIND_INSERT) begin
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = removed_r;
          out_count_nxt   = slt_pkg::COUNT_W'(count_nxt);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_r       <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r        <= kind_nxt;
    val_r         <= val_nxt;
    last_r        <= last_nxt;
    ptr_r         <= ptr_nxt;
    idx_r         <= idx_nxt;
    found_r       <= found_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

`ifndef ASSERT_OFF
  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  // the RAM is written only while an item is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN || state_r == S_FIN))
    else $error("RAM write outside an operation");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start");

  // a failed operation removes nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != slt_pkg::ST_OK) |-> out_removed_value == '0)
    else $error("failed operation reports a removed value");

  // full status only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == slt_pkg::ST_FULL) |->
    out_entry_count == slt_pkg::COUNT_W'(DEPTH))
    else $error("full status with table not full");
`endif

endmodule
`default_nettype wire

// File: tb/sorted_list_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_unit_tb
// Drives insert and delete items into the sorted list table and checks every
// result against a behavioral table kept in the bench. A directed opening
// covers empty, duplicate and extreme-value cases. The random part runs
// fill-heavy, drain-heavy and mixed phases in random order, so the table
// runs both full and empty. Both handshake sides idle at random, and the
// receiver holds off for long stretches to back the unit up.
// ----------------------------------------------------------------------------
module sorted_list_table_unit_tb;

  localparam int TABLE_DEPTH = 16;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_OPS = 950;
  localparam int MAX_WAIT = 13;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE = 40;
  localparam logic signed [slt_pkg::DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic signed [slt_pkg::DATA_W-1:0] MOST_POS = 32'h7fff_ffff;

  typedef struct packed {
    slt_pkg::kind_t                    kind;
    logic signed [slt_pkg::DATA_W-1:0] operand;
  } table_op_t;

  typedef struct packed {
    slt_pkg::status_t                  status;
    logic signed [slt_pkg::DATA_W-1:0] removed;
    logic [slt_pkg::COUNT_W-1:0]       count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [slt_pkg::KIND_W-1:0] in_kind = '0;
  logic signed [slt_pkg::DATA_W-1:0] in_operand_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [slt_pkg::STATUS_W-1:0] out_status;
  logic signed [slt_pkg::DATA_W-1:0] out_removed_value;
  logic [slt_pkg::COUNT_W-1:0] out_entry_count;

  // item traffic and checking
  table_op_t pending_ops[$];
  table_result_t predicted_results[$];
  logic signed [slt_pkg::DATA_W-1:0] recent_values[$];
  logic item_accepted = 1'b0;
  logic result_accepted = 1'b0;
  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;

  // bench copy of the table contents
  logic signed [slt_pkg::DATA_W-1:0] shadow_entries [TABLE_DEPTH];
  int shadow_count = 0;

  // handshake pacing
  int tx_wait_left = 0;
  int rx_wait_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  sorted_list_table_unit #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_entry_count  (out_entry_count)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // apply one operation to the shadow table and return its result
  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t res;
    logic signed [slt_pkg::DATA_W-1:0] val;
    int pos;
    int idx;
    int hit;
    val = op.operand;
    res.status = slt_pkg::ST_OK;
    res.removed = '0;
    if (op.kind == slt_pkg::KIND_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        res.status = slt_pkg::ST_FULL;
      end else begin
        // equal to the smallest goes in front, otherwise behind all equals
        pos = 0;
        if (shadow_count > 0 && !(val <= shadow_entries[0])) begin
          pos = 1;
          while (pos < shadow_count && shadow_entries[pos] <= val) pos++;
        end
        for (idx = shadow_count; idx > pos; idx--)
          shadow_entries[idx] = shadow_entries[idx-1];
        shadow_entries[pos] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = slt_pkg::ST_EMPTY;
    end else begin
      hit = -1;
      case (op.kind)
        slt_pkg::KIND_DEL_VALUE: begin
          for (idx = 0; idx < shadow_count && hit < 0; idx++)
            if (shadow_entries[idx] == val) hit = idx;
        end
        slt_pkg::KIND_DEL_MIN: hit = 0;
        default: hit = shadow_count - 1;
      endcase
      if (hit < 0) begin
        res.status = slt_pkg::ST_NOTFOUND;
      end else begin
        res.removed = shadow_entries[hit];
        for (idx = hit; idx + 1 < shadow_count; idx++)
          shadow_entries[idx] = shadow_entries[idx+1];
        shadow_count--;
      end
    end
    res.count = shadow_count[slt_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // operand mix: extremes, a narrow band for duplicates, and full range
  function automatic logic signed [slt_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2, 3, 4, 5: return int'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic add_op(slt_pkg::kind_t kind, logic signed [slt_pkg::DATA_W-1:0] operand);
    table_op_t op;
    op.kind = kind;
    op.operand = operand;
    pending_ops.push_back(op);
    if (kind == slt_pkg::KIND_INSERT) begin
      recent_values.push_back(operand);
      if (recent_values.size() > POOL_SIZE) void'(recent_values.pop_front());
    end
  endtask

  // sample both channels, check results, predict accepted items
  always @(posedge clk) begin : check_results
    table_op_t taken_op;
    table_result_t want;
    if (!rst_n) begin
      item_accepted <= 1'b0;
      result_accepted <= 1'b0;
    end else begin
      item_accepted <= in_valid && in_ready;
      result_accepted <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: status %0d removed %0d count %0d",
                     out_status, out_removed_value, out_entry_count);
        end else begin
          want = predicted_results.pop_front();
          if (out_status !== want.status || out_removed_value !== want.removed ||
              out_entry_count !== want.count) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: expected status %0d removed %0d count %0d, got %s",
                       want.status, $signed(want.removed), want.count,
                       $sformatf("status %0d removed %0d count %0d",
                                 out_status, out_removed_value, out_entry_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        taken_op.kind = slt_pkg::kind_t'(in_kind);
        taken_op.operand = in_operand_value;
        predicted_results.push_back(apply_table_op(taken_op));
      end
    end
  end

  // operation driver
  always @(negedge clk) begin : drive_ops
    table_op_t op;
    if (rst_n && (!in_valid || item_accepted)) begin
      if (in_valid) begin
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_wait_left = draw_wait(tx_burst);
      end
      if (tx_wait_left > 0) begin
        tx_wait_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_kind <= op.kind;
        in_operand_value <= op.operand;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with per-item stalls and long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && holds_done < 2 &&
          results_seen >= (holds_done == 0 ? 150 : 650)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (result_accepted) begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait_left = draw_wait(rx_burst);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int op_total;
    int phase_len;
    int insert_pct;
    int idx;
    slt_pkg::kind_t kind;
    logic signed [slt_pkg::DATA_W-1:0] val;

    // deletes of every kind on an empty table
    add_op(slt_pkg::KIND_DEL_MIN, 0);
    add_op(slt_pkg::KIND_DEL_MAX, 0);
    add_op(slt_pkg::KIND_DEL_VALUE, 0);
    // extremes, a duplicate of the smallest and a duplicate in the middle
    add_op(slt_pkg::KIND_INSERT, 0);
    add_op(slt_pkg::KIND_INSERT, MOST_POS);
    add_op(slt_pkg::KIND_INSERT, MOST_NEG);
    add_op(slt_pkg::KIND_INSERT, MOST_NEG);
    add_op(slt_pkg::KIND_INSERT, 0);
    add_op(slt_pkg::KIND_INSERT, -1);
    add_op(slt_pkg::KIND_INSERT, 1);
    // miss, match at the top end, first of two equals, both ends
    add_op(slt_pkg::KIND_DEL_VALUE, 5);
    add_op(slt_pkg::KIND_DEL_VALUE, MOST_POS);
    add_op(slt_pkg::KIND_DEL_VALUE, 0);
    add_op(slt_pkg::KIND_DEL_MAX, 0);
    add_op(slt_pkg::KIND_DEL_MIN, 0);
    // empty the table through each kind of delete
    add_op(slt_pkg::KIND_DEL_VALUE, -1);
    add_op(slt_pkg::KIND_DEL_MAX, 0);
    add_op(slt_pkg::KIND_DEL_VALUE, MOST_NEG);
    add_op(slt_pkg::KIND_INSERT, 7);
    add_op(slt_pkg::KIND_DEL_MIN, 0);
    add_op(slt_pkg::KIND_INSERT, -7);
    add_op(slt_pkg::KIND_DEL_MAX, 0);

    // random phases: fill-heavy, drain-heavy or mixed
    op_total = 0;
    while (op_total < RANDOM_OPS) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      for (idx = 0; idx < phase_len; idx++) begin
        if ($urandom_range(0, 99) < insert_pct) kind = slt_pkg::KIND_INSERT;
        else kind = slt_pkg::kind_t'($urandom_range(1, 3));
        if (kind == slt_pkg::KIND_DEL_VALUE && recent_values.size() != 0 &&
            $urandom_range(0, 9) < 7)
          val = recent_values[$urandom_range(0, recent_values.size() - 1)];
        else if (kind == slt_pkg::KIND_INSERT || kind == slt_pkg::KIND_DEL_VALUE)
          val = pick_value();
        else
          val = $urandom;
        add_op(kind, val);
        op_total++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
